/* design/dvrt_pkg.sv */
// shared types, codes and constants of the distance-vector route table
`default_nettype none
package dvrt_pkg;

    localparam int ROUTE_ENTRIES_DEF    = 32;
    localparam int NEIGHBOR_ENTRIES_DEF = 16;

    localparam int ADDR_W    = 32;
    localparam int METRIC_W  = 8;
    localparam int STATUS_W  = 4;
    localparam int REMOVED_W = 5;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [METRIC_W-1:0] TIMEOUT_RESET = 8'd35;
    localparam logic [METRIC_W-1:0] METRIC_MAX    = 8'd255;
    localparam logic [METRIC_W-1:0] METRIC_ONE    = 8'd1;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ADV     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CONNECT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_IMPROVED  = 4'd1;
    localparam logic [STATUS_W-1:0] ST_UNCHANGED = 4'd2;
    localparam logic [STATUS_W-1:0] ST_LOCAL     = 4'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 4'd4;
    localparam logic [STATUS_W-1:0] ST_FORWARD   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_DELIVER   = 4'd6;
    localparam logic [STATUS_W-1:0] ST_NOROUTE   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_TICK      = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDRESS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_TIMEOUT = 1'd1;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [ADDR_W-1:0]   sender_address;
        logic [ADDR_W-1:0]   dest_address;
        logic [METRIC_W-1:0] adv_metric;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_W-1:0]    next_hop;
        logic [METRIC_W-1:0]  route_metric;
        logic [REMOVED_W-1:0] removed_count;
    } t_res;

    typedef struct packed {
        logic [ADDR_W-1:0]   local_address;
        logic [METRIC_W-1:0] neighbor_timeout;
    } t_cfg;

    // route entry write data
    typedef struct packed {
        logic [ADDR_W-1:0]   dest;
        logic [ADDR_W-1:0]   hop;
        logic [METRIC_W-1:0] cost;
    } t_route_data;

    // neighbor entry write controls and data
    typedef struct packed {
        logic                we_addr;
        logic                we_timer;
        logic [ADDR_W-1:0]   addr;
        logic [METRIC_W-1:0] timer;
    } t_nbr_wr;

endpackage
`default_nettype wire

/* design/distance_vector_route_table.sv */
// top level of the distance-vector route table: ports, configuration and result register
`default_nettype none
// Distance-vector route table with neighbor liveness timers. Each request on the
// slave stream (advertised entry, neighbor connect, lookup, one-second tick) gives
// exactly one result beat on the master stream. The block works on one request at a
// time: s_axis_tready is high only while the sequencer is idle, and all table
// searches go one entry per cycle through a single 32-bit address comparator reading
// the route and neighbor memories (registered read). A lookup first checks the own
// address, then searches the routes; an advertised entry searches the neighbors and
// then the routes; a connect checks the own address and searches the routes and
// then the neighbors; a tick walks every neighbor slot, ages each live neighbor
// and, for every expired one, searches the routes to drop its route. The result
// sits in an output register, so a new request is taken while the previous result
// still waits; the sequencer waits only if a second result is ready before the
// first was taken. Configuration writes are taken at any time (ready always high)
// and must be made while no request is in flight.
// Route and neighbor valid bits are cleared by reset, so no clearing pass is needed.
module distance_vector_route_table
    import dvrt_pkg::*;
#(
    parameter int ROUTE_ENTRIES    = ROUTE_ENTRIES_DEF,
    parameter int NEIGHBOR_ENTRIES = NEIGHBOR_ENTRIES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request stream
    input  wire logic                 s_axis_tvalid,
    output      logic                 s_axis_tready,
    // [31:0] sender_address, [63:32] dest_address, [71:64] adv_metric
    input  wire logic [71:0]          s_axis_tdata,
    // [1:0] req_type
    input  wire logic [REQ_W-1:0]     s_axis_tuser,
    // result stream
    output      logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [31:0] next_hop, [39:32] route_metric, [44:40] removed_count, [47:45] zero
    output      logic [47:0]          m_axis_tdata,
    // [3:0] status
    output      logic [STATUS_W-1:0]  m_axis_tuser,
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output      logic                 o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ADDR_W-1:0]    i_cfg_data
);

    t_cfg r_cfg;
    t_req w_req;
    t_res w_res;
    logic w_res_valid;
    logic w_res_ready;

    logic r_m_valid;
    t_res r_m_res;

    // configuration registers, accepted every cycle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_address    <= '0;
            r_cfg.neighbor_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOCAL_ADDRESS:    r_cfg.local_address    <= i_cfg_data;
                CFG_NEIGHBOR_TIMEOUT: r_cfg.neighbor_timeout <= i_cfg_data[METRIC_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack the request beat
    assign w_req.req_type       = s_axis_tuser;
    assign w_req.sender_address = s_axis_tdata[31:0];
    assign w_req.dest_address   = s_axis_tdata[63:32];
    assign w_req.adv_metric     = s_axis_tdata[71:64];

    dvrt_seq #(
        .ROUTE_ENTRIES   (ROUTE_ENTRIES),
        .NEIGHBOR_ENTRIES(NEIGHBOR_ENTRIES)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_req_valid(s_axis_tvalid),
        .o_req_ready(s_axis_tready),
        .i_req      (w_req),
        .o_res_valid(w_res_valid),
        .i_res_ready(w_res_ready),
        .o_res      (w_res)
    );

    // output register: loads when empty or when its beat is being taken
    assign w_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
        end
        if (w_res_ready && w_res_valid) begin
            r_m_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res.status;
    assign m_axis_tdata  = {3'b000, r_m_res.removed_count, r_m_res.route_metric,
                            r_m_res.next_hop};

endmodule
`default_nettype wire

/* design/dvrt_route_ram.sv */
// route entry memory: destination, next hop and cost, one write and one registered read port
`default_nettype none
module dvrt_route_ram
    import dvrt_pkg::*;
#(
    parameter int DEPTH = ROUTE_ENTRIES_DEF,
    parameter int AW    = $clog2(ROUTE_ENTRIES_DEF)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_route_data   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output      t_route_data   o_rdata
);

    t_route_data r_mem [DEPTH];
    t_route_data r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* design/dvrt_nbr_ram.sv */
// neighbor memory: address and timer arrays, shared write address, registered read
`default_nettype none
module dvrt_nbr_ram
    import dvrt_pkg::*;
#(
    parameter int DEPTH = NEIGHBOR_ENTRIES_DEF,
    parameter int AW    = $clog2(NEIGHBOR_ENTRIES_DEF)
) (
    input  wire logic                i_clk,
    input  wire t_nbr_wr             i_wr,
    input  wire logic [AW-1:0]       i_waddr,
    input  wire logic [AW-1:0]       i_raddr,
    output      logic [ADDR_W-1:0]   o_raddr_val,
    output      logic [METRIC_W-1:0] o_rtimer
);

    logic [ADDR_W-1:0]   r_addr_mem  [DEPTH];
    logic [METRIC_W-1:0] r_timer_mem [DEPTH];
    logic [ADDR_W-1:0]   r_raddr_val;
    logic [METRIC_W-1:0] r_rtimer;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_addr) begin
            r_addr_mem[i_waddr] <= i_wr.addr;
        end
        if (i_wr.we_timer) begin
            r_timer_mem[i_waddr] <= i_wr.timer;
        end
        r_raddr_val <= r_addr_mem[i_raddr];
        r_rtimer    <= r_timer_mem[i_raddr];
    end

    assign o_raddr_val = r_raddr_val;
    assign o_rtimer    = r_rtimer;

endmodule
`default_nettype wire

/* design/dvrt_seq.sv */
// request sequencer: scans both tables through one shared address comparator
`default_nettype none
module dvrt_seq
    import dvrt_pkg::*;
#(
    parameter int ROUTE_ENTRIES    = ROUTE_ENTRIES_DEF,
    parameter int NEIGHBOR_ENTRIES = NEIGHBOR_ENTRIES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_req_valid,
    output      logic o_req_ready,
    input  wire t_req i_req,
    output      logic o_res_valid,
    input  wire logic i_res_ready,
    output      t_res o_res
);

    localparam int RIW  = $clog2(ROUTE_ENTRIES);
    localparam int NIW  = (NEIGHBOR_ENTRIES > 1) ? $clog2(NEIGHBOR_ENTRIES) : 1;
    localparam int MAXE = (ROUTE_ENTRIES > NEIGHBOR_ENTRIES) ? ROUTE_ENTRIES
                                                             : NEIGHBOR_ENTRIES;
    localparam int CW   = $clog2(MAXE + 1);
    localparam int NCW  = $clog2(NEIGHBOR_ENTRIES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOCAL = 4'd1;
    localparam logic [3:0] S_NSCAN = 4'd2;
    localparam logic [3:0] S_NPOST = 4'd3;
    localparam logic [3:0] S_RSCAN = 4'd4;
    localparam logic [3:0] S_RPOST = 4'd5;
    localparam logic [3:0] S_RDATA = 4'd6;
    localparam logic [3:0] S_TREAD = 4'd7;
    localparam logic [3:0] S_TDATA = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]                  r_state, n_state;
    t_req                        r_req, n_req;
    logic [ADDR_W-1:0]           r_key, n_key;
    logic [METRIC_W-1:0]         r_newc, n_newc;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic                        r_pend, n_pend;
    logic [CW-1:0]               r_pidx, n_pidx;
    logic                        r_rfound, n_rfound;
    logic [RIW-1:0]              r_ridx, n_ridx;
    logic                        r_rfree, n_rfree;
    logic [RIW-1:0]              r_rfidx, n_rfidx;
    logic                        r_nfound, n_nfound;
    logic [NIW-1:0]              r_nidx, n_nidx;
    logic                        r_nfree, n_nfree;
    logic [NIW-1:0]              r_nfidx, n_nfidx;
    logic [NCW-1:0]              r_tidx, n_tidx;
    logic [ROUTE_ENTRIES-1:0]    r_rvalid, n_rvalid;
    logic [NEIGHBOR_ENTRIES-1:0] r_nvalid, n_nvalid;
    t_res                        r_res, n_res;

    // shared comparator
    logic [ADDR_W-1:0] w_cmp_b;
    logic              w_eq;

    // memory ports
    logic                w_rwe;
    logic [RIW-1:0]      w_rwaddr;
    t_route_data         w_rwdata;
    logic [RIW-1:0]      w_rraddr;
    t_route_data         w_rrdata;
    t_nbr_wr             w_nwr;
    logic [NIW-1:0]      w_nwaddr;
    logic [NIW-1:0]      w_nraddr;
    logic [ADDR_W-1:0]   w_nraddr_val;
    logic [METRIC_W-1:0] w_nrtimer;

    logic [RIW-1:0] w_rpidx;
    logic [NIW-1:0] w_npidx;
    logic [NIW-1:0] w_tslot;

    assign w_rpidx = r_pidx[RIW-1:0];
    assign w_npidx = r_pidx[NIW-1:0];
    assign w_tslot = r_tidx[NIW-1:0];

    always_comb begin
        unique case (r_state)
            S_LOCAL: w_cmp_b = i_cfg.local_address;
            S_NSCAN: w_cmp_b = w_nraddr_val;
            default: w_cmp_b = w_rrdata.dest;
        endcase
    end
    assign w_eq = (r_key == w_cmp_b);

    assign w_rraddr = (r_state == S_RSCAN) ? r_cnt[RIW-1:0] : r_ridx;
    assign w_nraddr = (r_state == S_NSCAN) ? r_cnt[NIW-1:0] : w_tslot;

    dvrt_route_ram #(
        .DEPTH(ROUTE_ENTRIES),
        .AW   (RIW)
    ) u_route_ram (
        .i_clk  (i_clk),
        .i_we   (w_rwe),
        .i_waddr(w_rwaddr),
        .i_wdata(w_rwdata),
        .i_raddr(w_rraddr),
        .o_rdata(w_rrdata)
    );

    dvrt_nbr_ram #(
        .DEPTH(NEIGHBOR_ENTRIES),
        .AW   (NIW)
    ) u_nbr_ram (
        .i_clk      (i_clk),
        .i_wr       (w_nwr),
        .i_waddr    (w_nwaddr),
        .i_raddr    (w_nraddr),
        .o_raddr_val(w_nraddr_val),
        .o_rtimer   (w_nrtimer)
    );

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_key    = r_key;
        n_newc   = r_newc;
        n_cnt    = r_cnt;
        n_pend   = r_pend;
        n_pidx   = r_pidx;
        n_rfound = r_rfound;
        n_ridx   = r_ridx;
        n_rfree  = r_rfree;
        n_rfidx  = r_rfidx;
        n_nfound = r_nfound;
        n_nidx   = r_nidx;
        n_nfree  = r_nfree;
        n_nfidx  = r_nfidx;
        n_tidx   = r_tidx;
        n_rvalid = r_rvalid;
        n_nvalid = r_nvalid;
        n_res    = r_res;

        o_req_ready = 1'b0;
        o_res_valid = 1'b0;

        w_rwe    = 1'b0;
        w_rwaddr = r_ridx;
        w_rwdata = '{dest: r_req.dest_address, hop: r_req.sender_address, cost: r_newc};
        w_nwr    = '{we_addr: 1'b0, we_timer: 1'b0, addr: r_req.dest_address,
                     timer: i_cfg.neighbor_timeout};
        w_nwaddr = w_npidx;

        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_req    = i_req;
                    n_res    = '0;
                    n_key    = i_req.dest_address;
                    n_newc   = (i_req.adv_metric == METRIC_MAX) ? METRIC_MAX
                                                               : i_req.adv_metric + METRIC_ONE;
                    n_cnt    = '0;
                    n_pend   = 1'b0;
                    n_rfound = 1'b0;
                    n_rfree  = 1'b0;
                    n_nfound = 1'b0;
                    n_nfree  = 1'b0;
                    n_tidx   = '0;
                    unique case (i_req.req_type)
                        REQ_ADV: begin
                            n_key   = i_req.sender_address;
                            n_state = S_NSCAN;
                        end
                        REQ_TICK: n_state = S_TREAD;
                        default:  n_state = S_LOCAL;
                    endcase
                end
            end

            S_LOCAL: begin
                n_cnt  = '0;
                n_pend = 1'b0;
                if (r_req.req_type == REQ_ADV) begin
                    n_state = S_DONE;
                    if (w_eq) begin
                        n_res.status = ST_LOCAL;
                    end else if (r_rfree) begin
                        w_rwe                = 1'b1;
                        w_rwaddr             = r_rfidx;
                        n_rvalid[r_rfidx]    = 1'b1;
                        n_res.status         = ST_ADDED;
                        n_res.next_hop       = r_req.sender_address;
                        n_res.route_metric   = r_newc;
                    end else begin
                        n_res.status = ST_FULL;
                    end
                end else if (w_eq) begin
                    n_res.status = (r_req.req_type == REQ_LOOKUP) ? ST_DELIVER : ST_LOCAL;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_RSCAN;
                end
            end

            S_NSCAN: begin
                if (r_pend && r_nvalid[w_npidx]) begin
                    if (w_eq) begin
                        // every live copy of the sender gets its timer reloaded
                        if (r_req.req_type == REQ_ADV) begin
                            w_nwr.we_timer = 1'b1;
                        end
                        if (!r_nfound) begin
                            n_nfound = 1'b1;
                            n_nidx   = w_npidx;
                        end
                    end
                end
                if (r_pend && !r_nvalid[w_npidx] && !r_nfree) begin
                    n_nfree = 1'b1;
                    n_nfidx = w_npidx;
                end
                if (r_cnt < CW'(NEIGHBOR_ENTRIES)) begin
                    n_cnt  = r_cnt + 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_cnt;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_NPOST;
                    end
                end
            end

            S_NPOST: begin
                n_cnt  = '0;
                n_pend = 1'b0;
                if (r_req.req_type == REQ_ADV) begin
                    n_key   = r_req.dest_address;
                    n_state = S_RSCAN;
                end else begin
                    n_state = S_DONE;
                    if ((!r_rfound && !r_rfree) || (!r_nfound && !r_nfree)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        w_rwe          = 1'b1;
                        w_rwaddr       = r_rfound ? r_ridx : r_rfidx;
                        w_rwdata.hop   = r_req.dest_address;
                        w_rwdata.cost  = METRIC_ONE;
                        n_rvalid[w_rwaddr] = 1'b1;
                        w_nwr.we_addr  = 1'b1;
                        w_nwr.we_timer = 1'b1;
                        w_nwaddr       = r_nfound ? r_nidx : r_nfidx;
                        n_nvalid[w_nwaddr] = 1'b1;
                        n_res.status       = r_rfound ? ST_IMPROVED : ST_ADDED;
                        n_res.next_hop     = r_req.dest_address;
                        n_res.route_metric = METRIC_ONE;
                    end
                end
            end

            S_RSCAN: begin
                if (r_pend && r_rvalid[w_rpidx] && w_eq && !r_rfound) begin
                    n_rfound = 1'b1;
                    n_ridx   = w_rpidx;
                end
                if (r_pend && !r_rvalid[w_rpidx] && !r_rfree) begin
                    n_rfree = 1'b1;
                    n_rfidx = w_rpidx;
                end
                if (r_cnt < CW'(ROUTE_ENTRIES)) begin
                    n_cnt  = r_cnt + 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_cnt;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_RPOST;
                    end
                end
            end

            S_RPOST: begin
                // the route memory reads r_ridx here for the data state
                n_cnt  = '0;
                n_pend = 1'b0;
                unique case (r_req.req_type)
                    REQ_ADV: n_state = r_rfound ? S_RDATA : S_LOCAL;
                    REQ_CONNECT: begin
                        n_key   = r_req.dest_address;
                        n_state = S_NSCAN;
                    end
                    REQ_LOOKUP: begin
                        if (r_rfound) begin
                            n_state = S_RDATA;
                        end else begin
                            n_res.status = ST_NOROUTE;
                            n_state      = S_DONE;
                        end
                    end
                    default: begin
                        // expired neighbor: drop its route and the neighbor itself
                        if (r_rfound) begin
                            n_rvalid[r_ridx] = 1'b0;
                        end
                        n_nvalid[w_tslot] = 1'b0;
                        if (r_res.removed_count != '1) begin
                            n_res.removed_count = r_res.removed_count + 1'b1;
                        end
                        n_tidx  = r_tidx + 1'b1;
                        n_state = S_TREAD;
                    end
                endcase
            end

            S_RDATA: begin
                n_state = S_DONE;
                if (r_req.req_type == REQ_ADV && r_newc < w_rrdata.cost) begin
                    w_rwe              = 1'b1;
                    n_res.status       = ST_IMPROVED;
                    n_res.next_hop     = r_req.sender_address;
                    n_res.route_metric = r_newc;
                end else begin
                    n_res.status       = (r_req.req_type == REQ_ADV) ? ST_UNCHANGED
                                                                     : ST_FORWARD;
                    n_res.next_hop     = w_rrdata.hop;
                    n_res.route_metric = w_rrdata.cost;
                end
            end

            S_TREAD: begin
                if (r_tidx == NCW'(NEIGHBOR_ENTRIES)) begin
                    n_res.status = ST_TICK;
                    n_state      = S_DONE;
                end else if (!r_nvalid[w_tslot]) begin
                    n_tidx = r_tidx + 1'b1;
                end else begin
                    n_state = S_TDATA;
                end
            end

            S_TDATA: begin
                if (w_nrtimer == '0) begin
                    n_key    = w_nraddr_val;
                    n_cnt    = '0;
                    n_pend   = 1'b0;
                    n_rfound = 1'b0;
                    n_rfree  = 1'b0;
                    n_state  = S_RSCAN;
                end else begin
                    w_nwr.we_timer = 1'b1;
                    w_nwr.timer    = w_nrtimer - 1'b1;
                    w_nwaddr       = w_tslot;
                    n_tidx         = r_tidx + 1'b1;
                    n_state        = S_TREAD;
                end
            end

            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rvalid <= '0;
            r_nvalid <= '0;
        end else begin
            r_state  <= n_state;
            r_rvalid <= n_rvalid;
            r_nvalid <= n_nvalid;
        end
        r_req    <= n_req;
        r_key    <= n_key;
        r_newc   <= n_newc;
        r_cnt    <= n_cnt;
        r_pend   <= n_pend;
        r_pidx   <= n_pidx;
        r_rfound <= n_rfound;
        r_ridx   <= n_ridx;
        r_rfree  <= n_rfree;
        r_rfidx  <= n_rfidx;
        r_nfound <= n_nfound;
        r_nidx   <= n_nidx;
        r_nfree  <= n_nfree;
        r_nfidx  <= n_nfidx;
        r_tidx   <= n_tidx;
        r_res    <= n_res;
    end

    assign o_res = r_res;

    // an accepted request always leaves idle
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after accepting a request");

    // a matched route is still live when the scan result is used
    a_found_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RPOST && r_rfound) |-> r_rvalid[r_ridx])
        else $error("matched route not valid after scan");

    // the route scan never issues past the table
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RSCAN) |-> (r_cnt <= CW'(ROUTE_ENTRIES)))
        else $error("route scan counter beyond table depth");

    // a neighbor under aging is a live one
    a_tick_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TDATA) |-> r_nvalid[w_tslot])
        else $error("aging a neighbor slot that is not valid");

    // a finished result is held until taken
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(r_res)))
        else $error("result dropped before handoff");

endmodule
`default_nettype wire
